/* src/sme_pkg.sv */
// ----------------------------------------------------------------------------
// sme_pkg
// types and constants shared by the stack machine execute unit
// ----------------------------------------------------------------------------
package sme_pkg;

  localparam int WORD_W  = 32;  // data word, fixed by the transaction fields
  localparam int IP_W    = 16;  // program index, wraps modulo 2**IP_W
  localparam int CMD_W   = 4;
  localparam int ADDR_W  = 10;
  localparam int DEPTH_W = 9;
  localparam int STAT_W  = 2;

  // opcodes
  localparam logic [CMD_W-1:0] OP_LDC = 4'd0;
  localparam logic [CMD_W-1:0] OP_LD  = 4'd1;
  localparam logic [CMD_W-1:0] OP_ST  = 4'd2;
  localparam logic [CMD_W-1:0] OP_ADD = 4'd3;
  localparam logic [CMD_W-1:0] OP_SUB = 4'd4;
  localparam logic [CMD_W-1:0] OP_CMP = 4'd5;
  localparam logic [CMD_W-1:0] OP_JMP = 4'd6;
  localparam logic [CMD_W-1:0] OP_BR  = 4'd7;
  localparam logic [CMD_W-1:0] OP_RET = 4'd8;

  // status codes
  localparam logic [STAT_W-1:0] STAT_RUN   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_RET   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_UNDER = 2'd2;
  localparam logic [STAT_W-1:0] STAT_OVER  = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic signed [WORD_W-1:0] constant_value;
    logic [ADDR_W-1:0]        data_address;
    logic [IP_W-1:0]          jump_target;
  } sme_in_t;

  typedef struct packed {
    logic [IP_W-1:0]          next_ip;
    logic signed [WORD_W-1:0] top_value;
    logic [DEPTH_W-1:0]       stack_depth;
    logic [STAT_W-1:0]        status;
  } sme_out_t;

endpackage

/* src/stack_machine_execute.sv */
// ----------------------------------------------------------------------------
// stack_machine_execute
// execute unit of a small stack machine: operand stack and data memory in
// synchronous rams, top two stack entries cached in registers
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+-------------------
//   in      | input     | in_valid_i / in_ready_o    | in_data_i  sme_in_t
//   out     | output    | out_valid_o / out_ready_i  | out_data_o sme_out_t
//
// one instruction per cycle sustained while results are taken; an accepted
// instruction reads the data memory into the operand stage, then executes
// into the result register; after reset a clearing pass zeroes the data
// memory, with in_ready_o low until the pass has finished
// a stalled result holds the execute stage; one more instruction can wait
// in the operand stage while the result register is full
// ----------------------------------------------------------------------------
module stack_machine_execute
  import sme_pkg::*;
#(
  parameter int STACK_DEPTH = 256,
  parameter int DATA_DEPTH  = 1024
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  sme_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output sme_out_t out_data_o
);

  // stack count holds 0..STACK_DEPTH, stack ram index one bit less
  localparam int CW   = $clog2(STACK_DEPTH + 1);
  localparam int SAW  = $clog2(STACK_DEPTH);
  localparam int DAW  = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;
  localparam int AEXT = 20;  // wide enough for any data depth below 2**20
  localparam int DEXT = 17;  // wide enough for any stack count below 2**17

  // ---------------------------------------------------------------------
  // storage
  // ---------------------------------------------------------------------
  logic signed [WORD_W-1:0] stk_mem [STACK_DEPTH];
  logic signed [WORD_W-1:0] dmem    [DATA_DEPTH];

  // architectural state
  logic [IP_W-1:0]          ip_q, ip_d;
  logic [CW-1:0]            cnt_q, cnt_d;
  logic [STAT_W-1:0]        halt_q, halt_d;
  // cached stack: top entry, the one beneath, and the third from ram
  logic signed [WORD_W-1:0] top_q, top_d;
  logic signed [WORD_W-1:0] sec_q, sec_d;
  logic signed [WORD_W-1:0] third_q;

  // clearing pass
  logic                     clr_busy_q;
  logic [DAW-1:0]           clr_idx_q;

  // operand stage
  logic                     x_valid_q;
  sme_in_t                  x_q;
  logic signed [WORD_W-1:0] dm_rd_q;
  logic                     fwd_hit_q;
  logic signed [WORD_W-1:0] fwd_data_q;

  // result register
  logic                     out_valid_q;
  sme_out_t                 out_q;

  // ---------------------------------------------------------------------
  // handshake
  // ---------------------------------------------------------------------
  logic x_move, in_acc;

  assign x_move     = x_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !clr_busy_q && (!x_valid_q || x_move);
  assign in_acc     = in_valid_i && in_ready_o;

  // data memory addressing
  logic [AEXT-1:0] in_aext, x_aext;
  logic [DAW-1:0]  in_didx, x_didx;
  logic            x_in_range;

  assign in_aext    = AEXT'(in_data_i.data_address);
  assign x_aext     = AEXT'(x_q.data_address);
  assign in_didx    = in_aext[DAW-1:0];
  assign x_didx     = x_aext[DAW-1:0];
  assign x_in_range = x_aext < AEXT'(DATA_DEPTH);

  // load data, with a store executed in the same cycle as the read forwarded
  logic signed [WORD_W-1:0] ld_val;

  assign ld_val = !x_in_range ? '0 : (fwd_hit_q ? fwd_data_q : dm_rd_q);

  // ---------------------------------------------------------------------
  // execute
  // ---------------------------------------------------------------------
  logic            need_one, need_two, grows;
  logic            stk_we, dm_we;
  logic [CW-1:0]   stk_wcnt;
  logic signed [WORD_W-1:0] cmp_val;

  assign need_two = x_q.cmd inside {OP_ADD, OP_SUB, OP_CMP};
  assign need_one = x_q.cmd inside {OP_ST, OP_BR};
  assign grows    = x_q.cmd inside {OP_LDC, OP_LD, OP_CMP};
  assign cmp_val  = (top_q > sec_q) ? 32'sd1 : ((top_q < sec_q) ? -32'sd1 : 32'sd0);

  always_comb begin
    ip_d     = ip_q;
    cnt_d    = cnt_q;
    halt_d   = halt_q;
    top_d    = top_q;
    sec_d    = sec_q;
    stk_we   = 1'b0;
    stk_wcnt = cnt_q;
    dm_we    = 1'b0;
    if (x_valid_q && (halt_q == STAT_RUN)) begin
      if ((need_two && (cnt_q < CW'(2))) || (need_one && (cnt_q == '0))) begin
        halt_d = STAT_UNDER;
      end else if (grows && (cnt_q >= CW'(STACK_DEPTH))) begin
        halt_d = STAT_OVER;
      end else begin
        ip_d = IP_W'(ip_q + 1'b1);
        case (x_q.cmd)
          OP_LDC, OP_LD, OP_CMP: begin
            // push: new entry at index cnt_q
            if (x_q.cmd == OP_LDC) begin
              top_d = x_q.constant_value;
            end else if (x_q.cmd == OP_LD) begin
              top_d = ld_val;
            end else begin
              top_d = cmp_val;
            end
            sec_d  = top_q;
            cnt_d  = CW'(cnt_q + 1'b1);
            stk_we = 1'b1;
          end
          OP_ST: begin
            top_d = sec_q;
            sec_d = third_q;
            cnt_d = CW'(cnt_q - 1'b1);
            dm_we = x_in_range;
          end
          OP_ADD, OP_SUB: begin
            // result replaces the lower operand at index cnt_q-2
            top_d    = (x_q.cmd == OP_ADD) ? WORD_W'(top_q + sec_q)
                                           : WORD_W'(top_q - sec_q);
            sec_d    = third_q;
            cnt_d    = CW'(cnt_q - 1'b1);
            stk_we   = 1'b1;
            stk_wcnt = CW'(cnt_q - CW'(2));
          end
          OP_JMP: begin
            ip_d = x_q.jump_target;
          end
          OP_BR: begin
            if (top_q != '0) begin
              ip_d = x_q.jump_target;
            end
          end
          OP_RET: begin
            halt_d = STAT_RET;
            ip_d   = ip_q;
          end
          default: begin
            // unused opcodes only advance the pointer
          end
        endcase
      end
    end
  end

  // the stack ram always prefetches the entry third from the top
  logic [CW-1:0]  cnt_eff, rd_cnt;
  logic [SAW-1:0] stk_ridx, stk_widx;

  assign cnt_eff  = x_move ? cnt_d : cnt_q;
  assign rd_cnt   = CW'(cnt_eff - CW'(3));
  assign stk_ridx = rd_cnt[SAW-1:0];
  assign stk_widx = stk_wcnt[SAW-1:0];

  // store in execute hitting the address read for the incoming instruction
  logic st_hit;

  assign st_hit = x_move && dm_we && (x_q.data_address == in_data_i.data_address);

  // ---------------------------------------------------------------------
  // memories
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (x_move && stk_we) begin
      stk_mem[stk_widx] <= top_d;
    end
    third_q <= stk_mem[stk_ridx];
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      dmem[clr_idx_q] <= '0;
    end else if (x_move && dm_we) begin
      dmem[x_didx] <= top_q;
    end
    if (in_acc) begin
      dm_rd_q <= dmem[in_didx];
    end
  end

  // ---------------------------------------------------------------------
  // control registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q  <= 1'b1;
      clr_idx_q   <= '0;
      ip_q        <= '0;
      cnt_q       <= '0;
      halt_q      <= STAT_RUN;
      x_valid_q   <= 1'b0;
      fwd_hit_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (clr_busy_q) begin
        clr_idx_q <= DAW'(clr_idx_q + 1'b1);
        if (clr_idx_q == DAW'(DATA_DEPTH - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
      if (x_move) begin
        ip_q   <= ip_d;
        cnt_q  <= cnt_d;
        halt_q <= halt_d;
      end
      if (in_acc) begin
        x_valid_q <= 1'b1;
        fwd_hit_q <= st_hit;
      end else if (x_move) begin
        x_valid_q <= 1'b0;
      end
      if (x_move) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // payload registers
  // ---------------------------------------------------------------------
  logic [DEXT-1:0] depth_ext;

  assign depth_ext = DEXT'(cnt_d);

  always_ff @(posedge clk_i) begin
    if (x_move) begin
      top_q             <= top_d;
      sec_q             <= sec_d;
      out_q.next_ip     <= ip_d;
      out_q.top_value   <= (cnt_d != '0) ? top_d : '0;
      out_q.stack_depth <= depth_ext[DEPTH_W-1:0];
      out_q.status      <= halt_d;
    end
    if (in_acc) begin
      x_q        <= in_data_i;
      fwd_data_q <= top_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
